[hdl/nvh_pkg.sv]
// shared constants and types for the nearest-vertex height interpolator
package nvh_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;

    // input item modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // configuration register addresses
    localparam logic [0:0] REG_DEGEN = 1'b0;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [66:0] dividend;
        logic [66:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

[hdl/nvh_div.sv]
// restoring divider giving a 32-bit fraction, one quotient bit per cycle
module nvh_div
    import nvh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [67:0] rem_reg, rem_next;
    logic [66:0] dsr_reg, dsr_next;
    logic [31:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [68:0] shifted;
    logic [68:0] trial;

    // one restoring step
    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        trial     = shifted - {2'b00, dsr_reg};
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {1'b0, req.dividend};
            dsr_next  = req.divisor;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[68])
            begin
                rem_next = trial[67:0];
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[67:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

    // remainder stays below divisor while iterating
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !req.start |-> rem_reg < {1'b0, dsr_reg})
        else $error("divider remainder out of range");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

endmodule

[hdl/nearest_vertex_height_interpolator_unit.sv]
// top level: vertex store, nearest search sequencer and segment interpolation
// A word is taken when start is high and busy low. A query scans the stored
// vertices one per cycle through the store read port and distance unit, then
// may use the product steps and the divider; its result is shown for one
// cycle on result_valid and cannot be stalled.
module nearest_vertex_height_interpolator_unit
    import nvh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [0:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic               result_valid,
    output logic               status,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [7:0]         nearest_index,
    output logic               store_overflowed
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_LAST, S_RD0, S_RD1, S_LEN,
        S_DOT, S_CHECK, S_DIV, S_MUL, S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]       degen_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;

    // vertex store
    logic [31:0] mem_x [MAX_VERTICES];
    logic [31:0] mem_y [MAX_VERTICES];
    logic [31:0] mem_z [MAX_VERTICES];
    logic [IDX_W-1:0] rd_addr;
    logic [31:0] rd_x, rd_y, rd_z;

    logic [31:0]      qx_reg, qy_reg;
    logic [CNT_W-1:0] scan_reg;       // address issued
    logic [CNT_W-1:0] cmp_idx_reg;    // index of data in rd_*
    logic             cmp_vld_reg;
    logic [64:0]      best_d_reg;
    logic [IDX_W-1:0] best_reg;
    logic signed [32:0] x0_reg, y0_reg, z0_reg;
    logic signed [32:0] sx_reg, sy_reg, dz_reg;
    logic [31:0]      z1_reg;
    logic [66:0]      len2_reg;
    logic signed [67:0] dot_reg;
    logic [31:0]      zres_reg;
    logic             stat_reg;
    logic             rv_reg;
    logic [1:0]       step_reg;

    // shared signed multiplier, 33 x 33
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    logic [64:0]        dsq;
    logic signed [32:0] ddx, ddy;

    div_req_t dreq;
    div_rsp_t drsp;

    logic cfg_wr;
    logic acc;
    logic [63:0] zprod;
    logic signed [33:0] zsum;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == REG_DEGEN) ? degen_reg : '0;
    assign busy   = (state_reg != S_IDLE);
    assign acc    = start && !busy;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            degen_reg <= '0;
        else if (cfg_wr && paddr == REG_DEGEN)
            degen_reg <= pwdata;
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (acc && mode == MODE_APPEND && count_reg < CNT_W'(MAX_VERTICES))
        begin
            mem_x[count_reg[IDX_W-1:0]] <= coord_x;
            mem_y[count_reg[IDX_W-1:0]] <= coord_y;
            mem_z[count_reg[IDX_W-1:0]] <= coord_z;
        end
        rd_x <= mem_x[rd_addr];
        rd_y <= mem_y[rd_addr];
        rd_z <= mem_z[rd_addr];
    end

    always_comb
    begin
        rd_addr = scan_reg[IDX_W-1:0];
        if (state_reg == S_SCAN_LAST || state_reg == S_RD0)
            rd_addr = best_reg;
        else if (state_reg == S_RD1)
            rd_addr = best_reg + IDX_W'(1);
    end

    // squared distance of the word in the read register to the query
    assign ddx = $signed({qx_reg[31], qx_reg}) - $signed({rd_x[31], rd_x});
    assign ddy = $signed({qy_reg[31], qy_reg}) - $signed({rd_y[31], rd_y});
    assign dsq = 65'(ddx * ddx) + 65'(ddy * ddy);

    // shared multiplier operand select
    always_comb
    begin
        ma = sx_reg;
        mb = sx_reg;
        case (state_reg)
            S_LEN: begin ma = (step_reg == 2'd0) ? sx_reg : sy_reg; mb = ma; end
            S_DOT:
            begin
                ma = (step_reg == 2'd0) ? sx_reg : sy_reg;
                mb = (step_reg == 2'd0) ? $signed({qx_reg[31], qx_reg}) - x0_reg
                                        : $signed({qy_reg[31], qy_reg}) - y0_reg;
            end
            S_MUL: begin ma = dz_reg; mb = $signed({1'b0, drsp.quotient}); end
            default: ;
        endcase
    end
    assign mp    = ma * mb;
    assign zprod = 64'(mp >>> 32);
    assign zsum  = 34'(z0_reg) + 34'($signed(zprod[33:0]));

    assign dreq.start    = (state_reg == S_CHECK) && !(dot_reg <= 0)
                           && ($signed({1'b0, len2_reg}) > dot_reg)
                           && (len2_reg > 67'(degen_reg));
    assign dreq.dividend = dot_reg[66:0];
    assign dreq.divisor  = len2_reg;

    nvh_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (acc && mode == MODE_QUERY)
                    state_next = (count_reg == '0) ? S_DONE : S_SCAN;
            S_SCAN:
                if (scan_reg == count_reg) state_next = S_SCAN_LAST;
            S_SCAN_LAST: state_next = S_RD0;
            S_RD0:   state_next = S_RD1;
            S_RD1:
                state_next = (CNT_W'(best_reg) + CNT_W'(1) < count_reg) ? S_LEN : S_DONE;
            S_LEN:   if (step_reg == 2'd1) state_next = S_DOT;
            S_DOT:   if (step_reg == 2'd1) state_next = S_CHECK;
            S_CHECK: state_next = dreq.start ? S_DIV : S_DONE;
            S_DIV:   if (drsp.done) state_next = S_DONE;
            S_MUL:   state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_DIV && drsp.done) state_next = S_MUL;
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            rv_reg      <= 1'b0;
            cmp_vld_reg <= 1'b0;
            step_reg    <= '0;
            scan_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= (state_reg == S_DONE);
            if (acc && mode == MODE_CLEAR)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (acc && mode == MODE_APPEND)
            begin
                if (count_reg < CNT_W'(MAX_VERTICES))
                    count_reg <= count_reg + CNT_W'(1);
                else
                    ovf_reg <= 1'b1;
            end
            cmp_vld_reg <= (state_reg == S_SCAN) && (scan_reg != count_reg);
            if (state_reg == S_IDLE)
                scan_reg <= '0;
            else if (state_reg == S_SCAN && scan_reg != count_reg)
                scan_reg <= scan_reg + CNT_W'(1);
            if ((state_reg == S_LEN || state_reg == S_DOT) && step_reg == 2'd0)
                step_reg <= 2'd1;
            else
                step_reg <= 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && mode == MODE_QUERY)
        begin
            qx_reg   <= coord_x;
            qy_reg   <= coord_y;
            stat_reg <= (count_reg == '0);
            zres_reg <= '0;
            best_reg <= '0;
            store_overflowed <= ovf_reg;
        end
        cmp_idx_reg <= scan_reg;
        // running minimum, first wins on tie
        if (cmp_vld_reg && (cmp_idx_reg == '0 || dsq < best_d_reg))
        begin
            best_d_reg <= dsq;
            best_reg   <= cmp_idx_reg[IDX_W-1:0];
        end
        if (state_reg == S_RD1)
        begin
            x0_reg   <= $signed({rd_x[31], rd_x});
            y0_reg   <= $signed({rd_y[31], rd_y});
            z0_reg   <= $signed({rd_z[31], rd_z});
            zres_reg <= rd_z;
        end
        if (state_reg == S_LEN && step_reg == 2'd0)
        begin
            sx_reg <= $signed({rd_x[31], rd_x}) - x0_reg;
            sy_reg <= $signed({rd_y[31], rd_y}) - y0_reg;
            dz_reg <= $signed({rd_z[31], rd_z}) - z0_reg;
            z1_reg <= rd_z;
        end
        if (state_reg == S_LEN && step_reg == 2'd1)
            len2_reg <= 67'(sx_reg * sx_reg) + 67'(unsigned'(mp));
        if (state_reg == S_DOT)
            dot_reg <= (step_reg == 2'd0) ? 68'(mp) : dot_reg + 68'(mp);
        if (state_reg == S_CHECK && (len2_reg > 67'(degen_reg)) && !(dot_reg <= 0)
            && !($signed({1'b0, len2_reg}) > dot_reg))
            zres_reg <= z1_reg;
        if (state_reg == S_MUL)
            zres_reg <= zsum[31:0];
    end

    assign result_valid  = rv_reg;
    assign status        = stat_reg;
    assign out_x         = qx_reg;
    assign out_y         = qy_reg;
    assign out_z         = zres_reg;
    assign nearest_index = 8'(best_reg);

    // a result only follows the done step
    a_rv: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_DONE))
        else $error("result without done step");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond capacity");
    a_best: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD1 |-> CNT_W'(best_reg) < count_reg)
        else $error("nearest index beyond count");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result while busy");

endmodule

[sim/nvh_checker.sv]
// checker for the height interpolator: mirrors the vertex store, predicts heights, compares
module nvh_checker
    import nvh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [0:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic               result_valid,
    input  logic               status,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    input  logic signed [31:0] out_z,
    input  logic [7:0]         nearest_index,
    input  logic               store_overflowed,
    output int                 outstanding,
    output int                 fail_count,
    output int                 heights_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic               status;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [7:0]         idx;
        logic               ovf;
    } height_word_t;

    logic signed [31:0] vx [MAX_VERTICES];
    logic signed [31:0] vy [MAX_VERTICES];
    logic signed [31:0] vz [MAX_VERTICES];
    int                 vertex_total;
    logic               dropped_flag;
    logic [31:0]        degen_len_sq;
    height_word_t       pending_heights [$];

    // exact squared planar distance from the query to stored vertex i
    function automatic logic signed [127:0] dist_to_vertex(int i, logic signed [31:0] qx,
                                                           logic signed [31:0] qy);
        logic signed [127:0] dx, dy, t;
        dx = qx;
        t  = vx[i];
        dx = dx - t;
        dy = qy;
        t  = vy[i];
        dy = dy - t;
        return dx * dx + dy * dy;
    endfunction

    // project onto segment i..i+1, clamp and interpolate the height
    function automatic logic signed [31:0] segment_height(int i, logic signed [31:0] qx,
                                                         logic signed [31:0] qy);
        logic signed [127:0] x0, y0, z0, z1, sx, sy, tx, ty, len2, dot, q, dz, prod, lim;
        x0 = vx[i];
        y0 = vy[i];
        z0 = vz[i];
        z1 = vz[i+1];
        sx = vx[i+1];
        sx = sx - x0;
        sy = vy[i+1];
        sy = sy - y0;
        tx = qx;
        tx = tx - x0;
        ty = qy;
        ty = ty - y0;
        len2 = sx * sx + sy * sy;
        lim  = $signed({96'd0, degen_len_sq});
        if (len2 <= lim)
            return z0[31:0];
        dot = tx * sx + ty * sy;
        if (dot <= 0)
            return z0[31:0];
        if (dot >= len2)
            return z1[31:0];
        q    = (dot <<< 32) / len2;
        dz   = z1 - z0;
        prod = dz * q;
        prod = z0 + (prod >>> 32);
        return prod[31:0];
    endfunction

    function automatic height_word_t predict_height(logic signed [31:0] qx,
                                                    logic signed [31:0] qy);
        height_word_t        w;
        logic signed [127:0] best_d, d;
        int                  best;
        w.x = qx;
        w.y = qy;
        w.ovf = dropped_flag;
        w.status = 1'b1;
        w.z = '0;
        w.idx = '0;
        if (vertex_total == 0)
            return w;
        best = 0;
        best_d = dist_to_vertex(0, qx, qy);
        for (int i = 1; i < vertex_total; i++)
        begin
            d = dist_to_vertex(i, qx, qy);
            if (d < best_d)
            begin
                best_d = d;
                best = i;
            end
        end
        w.status = 1'b0;
        w.idx = best[7:0];
        w.z = (best + 1 < vertex_total) ? segment_height(best, qx, qy) : vz[best];
        return w;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        height_word_t e;
        if (!rst_n)
        begin
            vertex_total <= 0;
            dropped_flag <= 1'b0;
            degen_len_sq <= '0;
            pending_heights.delete();
            outstanding = 0;
            fail_count = 0;
            heights_checked = 0;
        end
        else
        begin
            // compare a result word with the oldest prediction
            if (result_valid)
            begin
                if (pending_heights.size() == 0)
                begin
                    $error("result word with no height pending");
                    fail_count++;
                end
                else
                begin
                    e = pending_heights.pop_front();
                    check_field("status", e.status, status);
                    check_field("out_x", e.x, out_x);
                    check_field("out_y", e.y, out_y);
                    check_field("out_z", e.z, out_z);
                    check_field("nearest_index", e.idx, nearest_index);
                    check_field("store_overflowed", e.ovf, store_overflowed);
                    heights_checked++;
                end
            end
            // register write
            if (psel && penable && pwrite && pready && paddr == REG_DEGEN)
                degen_len_sq <= pwdata;
            // accepted input word
            if (start && !busy)
            begin
                case (mode)
                    MODE_CLEAR:
                    begin
                        vertex_total <= 0;
                        dropped_flag <= 1'b0;
                    end
                    MODE_APPEND:
                    begin
                        if (vertex_total < MAX_VERTICES)
                        begin
                            vx[vertex_total] <= coord_x;
                            vy[vertex_total] <= coord_y;
                            vz[vertex_total] <= coord_z;
                            vertex_total <= vertex_total + 1;
                        end
                        else
                            dropped_flag <= 1'b1;
                    end
                    MODE_QUERY:
                        pending_heights = {pending_heights, predict_height(coord_x, coord_y)};
                    default: ;
                endcase
            end
            outstanding = pending_heights.size();
        end
    end
endmodule

[sim/tb.sv]
// testbench top: clock, reset, register writes and word stimulus for the interpolator
module tb
    import nvh_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] C_MAX = 32'sh7fff_ffff;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [0:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         mode = MODE_CLEAR;
    logic signed [31:0] coord_x = '0;
    logic signed [31:0] coord_y = '0;
    logic signed [31:0] coord_z = '0;
    logic               result_valid;
    logic               status;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [7:0]         nearest_index;
    logic               store_overflowed;
    int                 outstanding;
    int                 fail_count;
    int                 heights_checked;

    int                 gap_pct;
    int                 words_sent;
    logic signed [31:0] laid_x [$];
    logic signed [31:0] laid_y [$];

    nearest_vertex_height_interpolator_unit i_dut (.*);

    nvh_checker i_checker (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_word(logic [1:0] m, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        mode = m;
        coord_x = x;
        coord_y = y;
        coord_z = z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (m != MODE_UNUSED)
            words_sent++;
        if (m == MODE_APPEND)
        begin
            laid_x = {laid_x, x};
            laid_y = {laid_y, y};
        end
        if (m == MODE_CLEAR)
        begin
            laid_x.delete();
            laid_y.delete();
        end
    endtask

    // let every pending height arrive and the block settle
    task automatic drain;
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_degen(logic [31:0] v);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = REG_DEGEN;
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $signed($urandom_range(4096)) - 2048;
            2: return $signed($urandom_range(1 << 21)) - (1 << 20);
            3:
            begin
                case ($urandom_range(3))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return $signed($urandom_range(1 << 14)) - (1 << 13);
        endcase
    endfunction

    // one polyline: clear, an optional query, lay vertices, then a burst of queries
    task automatic run_polyline;
        int                 n_vert, n_query, k;
        logic signed [31:0] x, y, stepv;
        logic signed [32:0] mid;
        n_vert = ($urandom_range(39) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        if ($urandom_range(199) == 0)
            n_vert = 258;
        n_query = $urandom_range(2, 8);
        stepv = ($urandom_range(2) == 0) ? 32'sd8 : 32'sd4096;
        send_word(MODE_CLEAR, $urandom, $urandom, $urandom);
        if ($urandom_range(9) == 0)
            send_word(MODE_QUERY, rand_coord(), rand_coord(), $urandom);
        x = rand_coord();
        y = rand_coord();
        for (int i = 0; i < n_vert; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                x = rand_coord();
                y = rand_coord();
            end
            else if ($urandom_range(7) != 0)
            begin
                x = x + $signed($urandom_range(2 * stepv)) - stepv;
                y = y + $signed($urandom_range(2 * stepv)) - stepv;
            end
            send_word(MODE_APPEND, x, y, $urandom);
        end
        for (int i = 0; i < n_query; i++)
        begin
            k = $urandom_range(laid_x.size() - 1);
            case ($urandom_range(5))
                0: send_word(MODE_QUERY, rand_coord(), rand_coord(), $urandom);
                1:
                begin
                    if (k + 1 < laid_x.size())
                    begin
                        mid = (33'(laid_x[k]) + 33'(laid_x[k+1])) >>> 1;
                        x = mid[31:0];
                        mid = (33'(laid_y[k]) + 33'(laid_y[k+1])) >>> 1;
                        y = mid[31:0];
                    end
                    else
                    begin
                        x = laid_x[k];
                        y = laid_y[k];
                    end
                    send_word(MODE_QUERY, x, y, $urandom);
                end
                2: send_word(MODE_UNUSED, $urandom, $urandom, $urandom);
                default:
                    send_word(MODE_QUERY,
                              laid_x[k] + $signed($urandom_range(2 * stepv)) - stepv,
                              laid_y[k] + $signed($urandom_range(2 * stepv)) - stepv,
                              $urandom);
            endcase
        end
    endtask

    initial
    begin
        int target;
        gap_pct = 32;
        words_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        write_degen(32'd0);

        // directed: empty store, extremes, ties, clamping, degenerate segment, unused mode
        send_word(MODE_QUERY, 0, 0, 0);
        send_word(MODE_QUERY, C_MIN, C_MAX, C_MAX);
        send_word(MODE_APPEND, C_MIN, C_MIN, C_MIN);
        send_word(MODE_APPEND, C_MAX, C_MAX, C_MAX);
        send_word(MODE_QUERY, 0, 0, 0);
        send_word(MODE_QUERY, C_MIN, C_MIN, 0);
        send_word(MODE_QUERY, -1, 0, 0);
        send_word(MODE_QUERY, C_MAX, C_MIN, 0);
        send_word(MODE_UNUSED, C_MAX, C_MAX, C_MAX);
        send_word(MODE_CLEAR, 0, 0, 0);
        send_word(MODE_APPEND, 0, 0, 100);
        send_word(MODE_APPEND, 512, 0, -100);
        send_word(MODE_APPEND, 512, 0, 7);
        send_word(MODE_QUERY, 256, 0, 0);
        send_word(MODE_QUERY, 256, 1000, 0);
        send_word(MODE_QUERY, -500, 0, 0);
        send_word(MODE_QUERY, 600, 0, 0);
        send_word(MODE_QUERY, 100, -3, 0);
        send_word(MODE_QUERY, 1000, 0, 0);
        send_word(MODE_CLEAR, 0, 0, 0);
        send_word(MODE_QUERY, 5, 5, 0);
        drain();

        // three phases: sender gaps, then heavier gaps, then none
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: write_degen(32'hffff_ffff);
                1: write_degen($urandom_range(4000));
                default: write_degen(32'd0);
            endcase
            gap_pct = (ph == 0) ? 32 : (ph == 1) ? 86 : 0;
            target = words_sent + 440;
            while (words_sent < target)
                run_polyline();
            drain();
        end

        $display("sent %0d words over three gap settings and degenerate limits 0, max and mid;",
                 words_sent);
        $display("checked %0d height results", heights_checked);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

[sim.f]
hdl/nvh_pkg.sv
hdl/nvh_div.sv
hdl/nearest_vertex_height_interpolator_unit.sv
sim/nvh_checker.sv
sim/tb.sv
